/* design/cham64_pkg.sv */
// ----------------------------------------------------------------------------
// cham64_pkg
// Shared types, constants and round functions for the CHAM-64/128 encrypter.
// ----------------------------------------------------------------------------
package cham64_pkg;

    // number of ARX rounds applied to each block
    localparam int ROUND_COUNT = 80;

    // two rounds per pipeline stage
    localparam int ROUNDS_PER_STAGE = 2;
    localparam int NUM_STAGES = (ROUND_COUNT + ROUNDS_PER_STAGE - 1) / ROUNDS_PER_STAGE;

    // round counter must hold every index up to ROUND_COUNT
    localparam int RND_W = $clog2(ROUND_COUNT + 1);

    localparam int WORD_W = 16;
    localparam int NUM_RK = 16;
    localparam int RK_IDX_W = $clog2(NUM_RK);

    // register map, indexed by address bit 3
    localparam logic REG_KEY_LO = 1'b0;
    localparam logic REG_KEY_HI = 1'b1;

    typedef logic [WORD_W-1:0] word_t;

    // one block in flight: four state words
    typedef struct packed {
        word_t x0;
        word_t x1;
        word_t x2;
        word_t x3;
    } block_t;

    // sixteen round keys
    typedef word_t [NUM_RK-1:0] rk_set_t;

    function automatic word_t rol1(input word_t v);
        return {v[WORD_W-2:0], v[WORD_W-1]};
    endfunction

    function automatic word_t rol8(input word_t v);
        return {v[WORD_W-9:0], v[WORD_W-1:WORD_W-8]};
    endfunction

    function automatic word_t rol11(input word_t v);
        return {v[WORD_W-12:0], v[WORD_W-1:WORD_W-11]};
    endfunction

    // one ARX round; odd rounds swap the two rotations
    function automatic block_t arx_round(input block_t b, input logic [RND_W-1:0] rnd,
                                         input word_t rk);
        word_t  a;
        word_t  k;
        word_t  s;
        block_t o;
        a = b.x0 ^ WORD_W'(rnd);
        if (rnd[0])
        begin
            k = rol8(b.x1) ^ rk;
            s = k + a;
            o.x3 = rol1(s);
        end
        else
        begin
            k = rol1(b.x1) ^ rk;
            s = k + a;
            o.x3 = rol8(s);
        end
        o.x0 = b.x1;
        o.x1 = b.x2;
        o.x2 = b.x3;
        return o;
    endfunction

endpackage

/* design/cham64_key_sched.sv */
// ----------------------------------------------------------------------------
// cham64_key_sched
// Derives the sixteen round keys from the eight key words.
// ----------------------------------------------------------------------------
module cham64_key_sched (
    input  logic [63:0]               key_lo,
    input  logic [63:0]               key_hi,
    output cham64_pkg::rk_set_t       rk
);

    logic [127:0] key_all;

    assign key_all = {key_hi, key_lo};

    // rk[i] uses rol8, rk[(i+8)^1] uses rol11
    always_comb
    begin
        cham64_pkg::word_t kw;
        for (int i = 0; i < 8; i++)
        begin
            kw = key_all[cham64_pkg::WORD_W*i +: cham64_pkg::WORD_W];
            rk[i] = kw ^ cham64_pkg::rol1(kw) ^ cham64_pkg::rol8(kw);
            rk[(i + 8) ^ 1] = kw ^ cham64_pkg::rol1(kw) ^ cham64_pkg::rol11(kw);
        end
    end

endmodule

/* design/cham64_round_stage.sv */
// ----------------------------------------------------------------------------
// cham64_round_stage
// One pipeline stage: up to two ARX rounds followed by a register.
// ----------------------------------------------------------------------------
module cham64_round_stage (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              en,
    input  logic                              in_valid,
    input  cham64_pkg::block_t                in_blk,
    input  logic [cham64_pkg::RND_W-1:0]      rnd_first,
    input  logic [cham64_pkg::RND_W-1:0]      rnd_second,
    input  logic                              second_on,
    input  cham64_pkg::word_t                 rk_first,
    input  cham64_pkg::word_t                 rk_second,
    output logic                              out_valid,
    output cham64_pkg::block_t                out_blk
);

    logic               valid_reg;
    cham64_pkg::block_t blk_reg;
    cham64_pkg::block_t mid;
    cham64_pkg::block_t blk_next;

    // two rounds back to back; the second is skipped past the last round
    always_comb
    begin
        mid = cham64_pkg::arx_round(in_blk, rnd_first, rk_first);
        if (second_on)
        begin
            blk_next = cham64_pkg::arx_round(mid, rnd_second, rk_second);
        end
        else
        begin
            blk_next = mid;
        end
    end

    // valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    // data register
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            blk_reg <= blk_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_blk   = blk_reg;

endmodule

/* design/cham64_128_block_encrypt_top.sv */
// ----------------------------------------------------------------------------
// cham64_128_block_encrypt_top
// CHAM-64/128 encryption pipeline with an APB key register port.
// ----------------------------------------------------------------------------
// The block takes one 64-bit plaintext transaction per cycle while in_stall
// is low and returns its ciphertext once it has passed every stage: the rounds
// are unrolled two per register stage, and the last stage register drives the
// output. When the output is stalled while holding a result, the whole pipeline
// freezes and in_stall rises in the same cycle. The key lives in two 64-bit
// registers at byte addresses 0 (key words 0..3) and 8 (key words 4..7); write
// them only while no transaction is in flight.
module cham64_128_block_encrypt_top (
    input  logic        clk,
    input  logic        rst_n,
    // apb key port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    // plaintext channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [15:0] plain_word_0,
    input  logic [15:0] plain_word_1,
    input  logic [15:0] plain_word_2,
    input  logic [15:0] plain_word_3,
    // ciphertext channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] cipher_word_0,
    output logic [15:0] cipher_word_1,
    output logic [15:0] cipher_word_2,
    output logic [15:0] cipher_word_3
);

    localparam int NS = cham64_pkg::NUM_STAGES;

    logic [63:0]         key_lo_reg;
    logic [63:0]         key_hi_reg;
    logic                cfg_wr;
    cham64_pkg::rk_set_t rk;
    logic                en;

    logic                stage_vld [0:NS];
    cham64_pkg::block_t  stage_blk [0:NS];
    logic [NS-1:0]       vld_vec;

    // apb access
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_lo_reg <= '0;
            key_hi_reg <= '0;
        end
        else if (cfg_wr)
        begin
            case (paddr[3])
                cham64_pkg::REG_KEY_LO: key_lo_reg <= pwdata;
                cham64_pkg::REG_KEY_HI: key_hi_reg <= pwdata;
                default:                key_lo_reg <= key_lo_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3])
            cham64_pkg::REG_KEY_LO: prdata = key_lo_reg;
            cham64_pkg::REG_KEY_HI: prdata = key_hi_reg;
            default:                prdata = '0;
        endcase
    end

    // round keys
    cham64_key_sched u_key_sched (
        .key_lo (key_lo_reg),
        .key_hi (key_hi_reg),
        .rk     (rk)
    );

    // global advance: freeze only when a finished result is held
    assign en       = !(stage_vld[NS] && out_stall);
    assign in_stall = !en;

    assign stage_vld[0]    = in_valid;
    assign stage_blk[0].x0 = plain_word_0;
    assign stage_blk[0].x1 = plain_word_1;
    assign stage_blk[0].x2 = plain_word_2;
    assign stage_blk[0].x3 = plain_word_3;

    // round pipeline
    for (genvar s = 0; s < NS; s++)
    begin : g_stage
        cham64_round_stage u_stage (
            .clk        (clk),
            .rst_n      (rst_n),
            .en         (en),
            .in_valid   (stage_vld[s]),
            .in_blk     (stage_blk[s]),
            .rnd_first  (cham64_pkg::RND_W'(2 * s)),
            .rnd_second (cham64_pkg::RND_W'(2 * s + 1)),
            .second_on  ((2 * s + 1) < cham64_pkg::ROUND_COUNT),
            .rk_first   (rk[(2 * s) % cham64_pkg::NUM_RK]),
            .rk_second  (rk[(2 * s + 1) % cham64_pkg::NUM_RK]),
            .out_valid  (stage_vld[s+1]),
            .out_blk    (stage_blk[s+1])
        );
        assign vld_vec[s] = stage_vld[s+1];
    end

    // last stage register is the output register
    assign out_valid     = stage_vld[NS];
    assign cipher_word_0 = stage_blk[NS].x0;
    assign cipher_word_1 = stage_blk[NS].x1;
    assign cipher_word_2 = stage_blk[NS].x2;
    assign cipher_word_3 = stage_blk[NS].x3;

`ifndef NO_ASSERTIONS
    // a held result freezes every stage valid bit
    a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> vld_vec == $past(vld_vec))
        else $error("pipeline moved while stalled");

    // a result can only appear after the pipeline advanced
    a_out_rise: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(en))
        else $error("result appeared without an advance");

    // a low key write lands in the low key register
    a_key_lo: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_wr && paddr[3] == cham64_pkg::REG_KEY_LO) |=> key_lo_reg == $past(pwdata))
        else $error("low key write lost");
`endif

endmodule
